@@ rtl/inorder_sequence_reorder_top_assert.svh @@
// Assertion macros shared by the reorder block.
`ifndef INORDER_SEQUENCE_REORDER_TOP_ASSERT_SVH
`define INORDER_SEQUENCE_REORDER_TOP_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define ISR_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("reorder block assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ISR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("reorder block assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ISR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("reorder block assertion failed");

`endif

@@ rtl/isr_pkg.sv @@
package isr_pkg;

  // Send counter value after reset.
  localparam logic [31:0] INIT_SEQ_RESET = 32'd1010;

  // Upper bound on the results one input may cause.
  localparam int MAX_RESULTS = 16;

  // Request types.
  localparam logic REQ_SEND = 1'b0;
  localparam logic REQ_RECV = 1'b1;

  // Ordering modes; the unused code behaves as pass.
  localparam logic [1:0] MODE_DROP = 2'd0;
  localparam logic [1:0] MODE_HOLD = 2'd1;
  localparam logic [1:0] MODE_PASS = 2'd2;

  // Result outcomes.
  localparam logic [1:0] OUT_STAMPED   = 2'd0;
  localparam logic [1:0] OUT_DELIVERED = 2'd1;
  localparam logic [1:0] OUT_DROPPED   = 2'd2;
  localparam logic [1:0] OUT_SHELVED   = 2'd3;

  // Configuration register indexes, taken from address bit 2.
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_ORDER_MODE = 1'b0;
  localparam logic REG_INIT_SEQ   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHECK,
    ST_FINAL
  } isr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic finish;
    logic start;
    logic emit;
    logic advance;
    logic read_more;
    logic flush;
  } isr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic drain;
    logic nonempty;
    logic more;
    logic out_free;
  } isr_sts_t;

endpackage

@@ rtl/isr_if.sv @@
// Request channel.
interface isr_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] seq_in;
  logic [15:0] packet_handle;

  modport source (output valid, req_type, seq_in, packet_handle, input ready);
  modport sink (input valid, req_type, seq_in, packet_handle, output ready);
endinterface

// Result channel.
interface isr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  outcome;
  logic [31:0] seq_out;
  logic [15:0] handle_out;
  logic        last_of_run;

  modport source (output valid, outcome, seq_out, handle_out, last_of_run, input ready);
  modport sink (input valid, outcome, seq_out, handle_out, last_of_run, output ready);
endinterface

@@ rtl/isr_ctrl.sv @@
module isr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  isr_pkg::isr_sts_t sts,
  output isr_pkg::isr_cmd_t cmd
);

  isr_pkg::isr_state_t state_r;
  isr_pkg::isr_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      isr_pkg::ST_IDLE: begin
        // Requests are refused while reset is held.
        in_ready = rst_n;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = isr_pkg::ST_DECIDE;
        end
      end
      isr_pkg::ST_DECIDE: begin
        // An in-order packet with shelved successors starts a drain.
        if (sts.drain) begin
          cmd.start = 1'b1;
          state_nxt = isr_pkg::ST_CHECK;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = isr_pkg::ST_IDLE;
        end
      end
      isr_pkg::ST_CHECK: begin
        // Send the pending result once the slot read tells whether it is the last.
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.nonempty) begin
            cmd.advance = 1'b1;
            if (sts.more) begin
              cmd.read_more = 1'b1;
            end else begin
              state_nxt = isr_pkg::ST_FINAL;
            end
          end else begin
            state_nxt = isr_pkg::ST_IDLE;
          end
        end
      end
      isr_pkg::ST_FINAL: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = isr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = isr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/isr_dp.sv @@
module isr_dp #(
  parameter int BUFFER_SIZE = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  isr_pkg::isr_cmd_t cmd,
  output isr_pkg::isr_sts_t sts,
  input  logic              req_type,
  input  logic [31:0]       seq_in,
  input  logic [15:0]       packet_handle,
  input  logic [1:0]        order_mode,
  input  logic              init_load,
  input  logic [31:0]       init_value,
  isr_out_if.source         out_ch
);

  localparam int SlotW = $clog2(BUFFER_SIZE);
  localparam int DrainMax = (BUFFER_SIZE - 1 < isr_pkg::MAX_RESULTS - 1) ?
                            BUFFER_SIZE - 1 : isr_pkg::MAX_RESULTS - 1;
  localparam int StepW = $clog2(DrainMax + 1);

  // Byte weights of a 32-bit value modulo the shelf depth.
  localparam int C1 = 256 % BUFFER_SIZE;
  localparam int C2 = (C1 * 256) % BUFFER_SIZE;
  localparam int C3 = (C2 * 256) % BUFFER_SIZE;
  localparam int SumW = 18;
  localparam int Sh = SumW + SlotW;
  localparam int ProdW = SumW + Sh;
  localparam longint unsigned Recip =
    ((64'd1 << Sh) + longint'(BUFFER_SIZE) - 64'd1) / longint'(BUFFER_SIZE);

  // Latched request.
  logic            typ_r;
  logic [31:0]     seq_r;
  logic [15:0]     hdl_r;
  logic [SumW-1:0] sum_r;

  // Connection state.
  logic [31:0] send_cnt_r;
  logic [31:0] last_r;
  logic [31:0] high_r;

  // Drain walk.
  logic [31:0]      pend_seq_r;
  logic [15:0]      pend_hdl_r;
  logic [31:0]      i_r;
  logic [SlotW-1:0] islot_r;
  logic [StepW-1:0] steps_r;

  // Handle shelf.
  logic [15:0]            mem [BUFFER_SIZE];
  logic [BUFFER_SIZE-1:0] vld_r;
  logic [15:0]            rd_data_r;

  // Result register.
  logic        out_valid_r;
  logic [1:0]  out_outcome_r;
  logic [31:0] out_seq_r;
  logic [15:0] out_hdl_r;
  logic        out_last_r;

  logic [SumW-1:0]  sum_nxt;
  logic [ProdW-1:0] prod;
  logic [SumW-1:0]  quot;
  logic [SumW-1:0]  rem_full;
  logic [SlotW-1:0] slot;
  logic [SlotW-1:0] slot_inc;
  logic [SlotW-1:0] islot_inc;
  logic [SlotW-1:0] rd_addr;
  logic             rd_en;
  logic [31:0]      seq_p1;
  logic [31:0]      send_p1;
  logic [31:0]      i_p1;
  logic             hold_acc;
  logic [1:0]       res_outcome;
  logic [31:0]      res_seq;
  logic             upd_send;
  logic             upd_last;
  logic             shelve;
  logic             out_load;

  // Fold the sequence number into a short sum with the same residue.
  assign sum_nxt = SumW'(seq_in[7:0])
                 + SumW'(seq_in[15:8])  * SumW'(C1)
                 + SumW'(seq_in[23:16]) * SumW'(C2)
                 + SumW'(seq_in[31:24]) * SumW'(C3);

  // Residue of the folded sum by reciprocal multiplication.
  assign prod     = ProdW'(sum_r) * ProdW'(Recip);
  assign quot     = SumW'(prod >> Sh);
  assign rem_full = sum_r - SumW'(quot * SumW'(BUFFER_SIZE));
  assign slot     = rem_full[SlotW-1:0];

  assign slot_inc  = (slot == SlotW'(BUFFER_SIZE - 1)) ? '0 : slot + 1'b1;
  assign islot_inc = (islot_r == SlotW'(BUFFER_SIZE - 1)) ? '0 : islot_r + 1'b1;

  assign seq_p1  = seq_r + 32'd1;
  assign send_p1 = send_cnt_r + 32'd1;
  assign i_p1    = i_r + 32'd1;
  assign hold_acc = (last_r == 32'd0) || (seq_r == last_r + 32'd1);

  // Outcome of a request that needs no drain.
  always_comb begin
    res_outcome = isr_pkg::OUT_DELIVERED;
    res_seq     = seq_r;
    upd_send    = 1'b0;
    upd_last    = 1'b0;
    shelve      = 1'b0;
    if (typ_r == isr_pkg::REQ_SEND) begin
      res_outcome = isr_pkg::OUT_STAMPED;
      res_seq     = send_p1;
      upd_send    = 1'b1;
    end else begin
      case (order_mode)
        isr_pkg::MODE_DROP: begin
          if (last_r < seq_r) begin
            upd_last = 1'b1;
          end else begin
            res_outcome = isr_pkg::OUT_DROPPED;
          end
        end
        isr_pkg::MODE_HOLD: begin
          if (hold_acc) begin
            upd_last = 1'b1;
          end else begin
            res_outcome = isr_pkg::OUT_SHELVED;
            shelve      = 1'b1;
          end
        end
        default: begin
          res_outcome = isr_pkg::OUT_DELIVERED;
        end
      endcase
    end
  end

  // Status toward the controller.
  assign sts.drain    = (typ_r == isr_pkg::REQ_RECV) && (order_mode == isr_pkg::MODE_HOLD) &&
                        hold_acc && (seq_p1 <= high_r);
  assign sts.nonempty = (rd_data_r != 16'd0);
  assign sts.more     = (({1'b0, steps_r} + 1'b1) < (StepW + 1)'(DrainMax)) && (i_p1 <= high_r);
  assign sts.out_free = !out_valid_r || out_ch.ready;

  assign out_load = cmd.finish || cmd.emit || cmd.flush;

  // Connection state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_cnt_r  <= isr_pkg::INIT_SEQ_RESET;
      last_r      <= 32'd0;
      high_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (init_load) begin
        send_cnt_r <= init_value;
      end
      if (cmd.finish) begin
        if (upd_send) begin
          send_cnt_r <= send_p1;
        end
        if (upd_last) begin
          last_r <= seq_r;
        end
        if (shelve && (high_r < seq_r)) begin
          high_r <= seq_r;
        end
      end
      if (cmd.start) begin
        last_r <= seq_r;
      end
      if (cmd.advance) begin
        last_r <= i_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request latch, drain walk and result payload.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      typ_r <= req_type;
      seq_r <= seq_in;
      hdl_r <= packet_handle;
      sum_r <= sum_nxt;
    end
    if (cmd.start) begin
      pend_seq_r <= seq_r;
      pend_hdl_r <= hdl_r;
      i_r        <= seq_p1;
      islot_r    <= slot_inc;
      steps_r    <= '0;
    end
    if (cmd.advance) begin
      pend_seq_r <= i_r;
      pend_hdl_r <= rd_data_r;
      i_r        <= i_p1;
      islot_r    <= islot_inc;
      steps_r    <= steps_r + 1'b1;
    end
    if (cmd.finish) begin
      out_outcome_r <= res_outcome;
      out_seq_r     <= res_seq;
      out_hdl_r     <= hdl_r;
      out_last_r    <= 1'b1;
    end else if (cmd.emit || cmd.flush) begin
      out_outcome_r <= isr_pkg::OUT_DELIVERED;
      out_seq_r     <= pend_seq_r;
      out_hdl_r     <= pend_hdl_r;
      out_last_r    <= cmd.flush || !sts.nonempty;
    end
  end

  // Slot valid bits: set when shelved, cleared when drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (cmd.finish && shelve) begin
        vld_r[slot] <= 1'b1;
      end
      if (cmd.advance) begin
        vld_r[islot_r] <= 1'b0;
      end
    end
  end

  assign rd_en   = cmd.start || cmd.read_more;
  assign rd_addr = cmd.start ? slot_inc : islot_inc;

  // Shelf memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.finish && shelve) begin
      mem[slot] <= hdl_r;
    end
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : 16'd0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.outcome     = out_outcome_r;
  assign out_ch.seq_out     = out_seq_r;
  assign out_ch.handle_out  = out_hdl_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

@@ rtl/inorder_sequence_reorder_top.sv @@
// A request is latched, then decided; its result is registered once the output register is free.
// Requests are taken one at a time; a hold-mode drain delivers its shelved handles one by one,
// paced by the single registered read port of the handle shelf and by output stalls.
// Reset: rst_n is synchronous and active low; it restores both registers and the counters,
// and clears every shelf valid bit in the same cycle, so no clearing pass follows.
module inorder_sequence_reorder_top #(
  parameter int BUFFER_SIZE = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  isr_in_if.sink                         in_ch,
  isr_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [isr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [1:0]        mode_r;
  logic [31:0]       init_r;
  logic              cfg_wr;
  logic              reg_idx;
  logic              init_load;
  isr_pkg::isr_cmd_t cmd;
  isr_pkg::isr_sts_t sts;

  // Configuration registers behind the APB port.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_wr    = psel && penable && pwrite;
  assign init_load = cfg_wr && (reg_idx == isr_pkg::REG_INIT_SEQ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= isr_pkg::MODE_HOLD;
      init_r <= isr_pkg::INIT_SEQ_RESET;
    end else if (cfg_wr) begin
      if (reg_idx == isr_pkg::REG_ORDER_MODE) begin
        mode_r <= pwdata[1:0];
      end else begin
        init_r <= pwdata;
      end
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      isr_pkg::REG_ORDER_MODE: prdata = {30'd0, mode_r};
      isr_pkg::REG_INIT_SEQ:   prdata = init_r;
      default:                 prdata = 32'd0;
    endcase
  end

  isr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  isr_dp #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (in_ch.req_type),
    .seq_in        (in_ch.seq_in),
    .packet_handle (in_ch.packet_handle),
    .order_mode    (mode_r),
    .init_load     (init_load),
    .init_value    (pwdata),
    .out_ch        (out_ch)
  );

`include "inorder_sequence_reorder_top_assert.svh"

  // A result is loaded only when the output register can take it.
  `ISR_ASSERT_SAME(a_no_overwrite, cmd.finish || cmd.emit || cmd.flush, sts.out_free)
  // At most one result source drives the output register in a cycle.
  `ISR_ASSERT_ALWAYS(a_one_source, $onehot0({cmd.finish, cmd.start, cmd.emit, cmd.flush}))
  // A new request is not taken while the previous one is still being decided.
  `ISR_ASSERT_NEXT(a_one_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready)

endmodule

@@ dv/inorder_sequence_reorder_checker.sv @@
`timescale 1ns / 100ps

module inorder_sequence_reorder_checker #(
  parameter int SHELF_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_req_type,
  input  logic [31:0]                    in_seq,
  input  logic [15:0]                    in_handle,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [1:0]                     out_outcome,
  input  logic [31:0]                    out_seq,
  input  logic [15:0]                    out_handle,
  input  logic                           out_last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [isr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output int                             mismatches,
  output int                             results_due,
  output int                             results_checked,
  output int                             longest_run,
  output logic [31:0]                    rx_last
);

  typedef struct packed {
    logic [1:0]  outcome;
    logic [31:0] seq;
    logic [15:0] handle;
    logic        last;
  } reorder_result_t;

  // Results still owed by the block, oldest first.
  reorder_result_t due_q[$];
  reorder_result_t head;

  // Shadow copy of the configuration and the connection state.
  logic [1:0]  order_mode;
  logic [31:0] send_seq;
  logic [31:0] hi_shelved;
  logic [15:0] shelf [SHELF_DEPTH];

  initial begin
    mismatches      = 0;
    results_due     = 0;
    results_checked = 0;
    longest_run     = 0;
  end

  function automatic reorder_result_t make_result(input logic [1:0] outcome,
                                                  input logic [31:0] seq,
                                                  input logic [15:0] handle);
    return {outcome, seq, handle, 1'b0};
  endfunction

  // Work out every result one accepted request causes and queue them in order.
  function automatic void predict_results(input logic req, input logic [31:0] seq,
                                          input logic [15:0] handle);
    reorder_result_t run [isr_pkg::MAX_RESULTS];
    int n;
    int slot;
    logic [31:0] idx;
    logic walking;
    n = 0;
    if (req == isr_pkg::REQ_SEND) begin
      send_seq = send_seq + 32'd1;
      run[n] = make_result(isr_pkg::OUT_STAMPED, send_seq, handle);
      n++;
    end else if (order_mode == isr_pkg::MODE_DROP) begin
      if (rx_last < seq) begin
        rx_last = seq;
        run[n] = make_result(isr_pkg::OUT_DELIVERED, seq, handle);
      end else begin
        run[n] = make_result(isr_pkg::OUT_DROPPED, seq, handle);
      end
      n++;
    end else if (order_mode == isr_pkg::MODE_HOLD) begin
      if (rx_last == 32'd0 || seq == rx_last + 32'd1) begin
        rx_last = seq;
        run[n] = make_result(isr_pkg::OUT_DELIVERED, seq, handle);
        n++;
        // Walk the shelf behind the accepted packet until a hole or the window end.
        idx = seq + 32'd1;
        walking = 1'b1;
        while (walking && n < SHELF_DEPTH && n < isr_pkg::MAX_RESULTS &&
               idx <= hi_shelved) begin
          slot = idx % SHELF_DEPTH;
          if (shelf[slot] == 16'd0) begin
            walking = 1'b0;
          end else begin
            run[n] = make_result(isr_pkg::OUT_DELIVERED, idx, shelf[slot]);
            n++;
            rx_last = idx;
            shelf[slot] = 16'd0;
            idx = idx + 32'd1;
          end
        end
      end else begin
        slot = seq % SHELF_DEPTH;
        shelf[slot] = handle;
        if (hi_shelved < seq) hi_shelved = seq;
        run[n] = make_result(isr_pkg::OUT_SHELVED, seq, handle);
        n++;
      end
    end else begin
      // Pass mode and the unused mode code deliver everything.
      run[n] = make_result(isr_pkg::OUT_DELIVERED, seq, handle);
      n++;
    end
    run[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) due_q.push_back(run[k]);
    if (n > longest_run) longest_run = n;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Track configuration writes, predict on each request and compare each result.
  always @(posedge clk) begin
    if (!rst_n) begin
      order_mode = isr_pkg::MODE_HOLD;
      send_seq   = isr_pkg::INIT_SEQ_RESET;
      rx_last    = 32'd0;
      hi_shelved = 32'd0;
      for (int k = 0; k < SHELF_DEPTH; k++) shelf[k] = 16'd0;
      due_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == isr_pkg::REG_ORDER_MODE) begin
          order_mode = pwdata[1:0];
        end else begin
          send_seq = pwdata;
        end
      end
      if (in_valid && in_ready) predict_results(in_req_type, in_seq, in_handle);
      if (out_valid && out_ready) begin
        results_checked++;
        if (due_q.size() == 0) begin
          mismatches++;
          $display("%0t: result expected none, actual outcome %0d seq %0h handle %0h last %b",
                   $time, out_outcome, out_seq, out_handle, out_last);
        end else begin
          head = due_q.pop_front();
          check_field("outcome", 32'(head.outcome), 32'(out_outcome));
          check_field("seq_out", head.seq, out_seq);
          check_field("handle_out", 32'(head.handle), 32'(out_handle));
          check_field("last_of_run", 32'(head.last), 32'(out_last));
        end
      end
    end
    results_due = due_q.size();
  end

endmodule

@@ dv/inorder_sequence_reorder_top_tb.sv @@
`timescale 1ns / 100ps

module inorder_sequence_reorder_top_tb;

  localparam int SHELF_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 360;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 40;

  // The mode code the block leaves unused; it behaves as pass.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Arrival orders for a window of consecutive sequence numbers.
  localparam int ORDER_ASCENDING  = 0;
  localparam int ORDER_DESCENDING = 1;
  localparam int ORDER_SHUFFLED   = 2;

  logic                           clk;
  logic                           rst_n;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [isr_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0]                    pwdata;
  logic [31:0]                    prdata;
  logic                           pready;

  isr_in_if  in_if ();
  isr_out_if out_if ();

  int          mismatches;
  int          results_due;
  int          results_checked;
  int          longest_run;
  logic [31:0] rx_last;

  int items_sent   = 0;
  int sends_sent   = 0;
  int phases       = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;
  int ready_pct    = 100;
  int ready_hold   = 0;

  inorder_sequence_reorder_top #(
    .BUFFER_SIZE(SHELF_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  inorder_sequence_reorder_checker #(
    .SHELF_DEPTH(SHELF_DEPTH)
  ) chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_if.valid),
    .in_ready       (in_if.ready),
    .in_req_type    (in_if.req_type),
    .in_seq         (in_if.seq_in),
    .in_handle      (in_if.packet_handle),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_outcome    (out_if.outcome),
    .out_seq        (out_if.seq_out),
    .out_handle     (out_if.handle_out),
    .out_last       (out_if.last_of_run),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatches     (mismatches),
    .results_due    (results_due),
    .results_checked(results_checked),
    .longest_run    (longest_run),
    .rx_last        (rx_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The result side stalls with a readiness that changes every so often.
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_pct  = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(20, 95);
      ready_hold = $urandom_range(20, 150);
    end else begin
      ready_hold--;
    end
    out_if.ready <= ($urandom_range(1, 100) <= ready_pct);
  end

  // Give up when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one request and hold it until the block takes it; bursts end in random gaps.
  task automatic put_request(input logic req, input logic [31:0] seq,
                             input logic [15:0] handle);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
    burst_left--;
    in_if.valid         <= 1'b1;
    in_if.req_type      <= req;
    in_if.seq_in        <= seq;
    in_if.packet_handle <= handle;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    if (req == isr_pkg::REQ_SEND) sends_sent++;
  endtask

  // Stop offering requests and wait until every owed result has come out.
  task automatic wait_quiet();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // One register write; the caller lowers psel after the last one.
  task automatic cfg_write(input logic index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // Reprogram the block once it is idle.
  task automatic configure(input logic [1:0] mode, input logic load_init,
                           input logic [31:0] init_seq);
    wait_quiet();
    if (load_init) cfg_write(isr_pkg::REG_INIT_SEQ, init_seq);
    cfg_write(isr_pkg::REG_ORDER_MODE, {30'd0, mode});
    psel    <= 1'b0;
    penable <= 1'b0;
    phases++;
  endtask

  initial begin
    logic [1:0]  mode_pick;
    logic [31:0] base;
    int          pick;
    int          width;
    int          shape;
    int          pos;
    int          tmp;
    int          directed_items;
    int          order [SHELF_DEPTH];

    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.req_type      = isr_pkg::REQ_SEND;
    in_if.seq_in        = 32'd0;
    in_if.packet_handle = 16'd1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = 32'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Stamping from the reset start value, with extreme field values.
    put_request(isr_pkg::REQ_SEND, 32'd0, 16'h0001);
    put_request(isr_pkg::REQ_SEND, 32'hFFFF_FFFF, 16'hFFFF);
    // Hold mode: first packet is taken outright, then gaps are shelved and drained.
    put_request(isr_pkg::REQ_RECV, 32'd100, 16'hA5A5);
    put_request(isr_pkg::REQ_RECV, 32'd103, 16'h0003);
    put_request(isr_pkg::REQ_RECV, 32'd102, 16'h0002);
    // This one lands in the slot that 103 already holds.
    put_request(isr_pkg::REQ_RECV, 32'd119, 16'h0119);
    put_request(isr_pkg::REQ_RECV, 32'd106, 16'h0006);
    put_request(isr_pkg::REQ_RECV, 32'd105, 16'h0005);
    // The drain picks up the aliased handle as 103 and stops at an empty slot; the next one drains 105 and 106.
    put_request(isr_pkg::REQ_RECV, 32'd101, 16'h0001);
    put_request(isr_pkg::REQ_RECV, 32'd104, 16'h0004);
    // A stale sequence number is shelved, not delivered.
    put_request(isr_pkg::REQ_RECV, 32'd100, 16'h0100);

    // Drop mode: above, equal, below, near the top and wrapped back to zero.
    configure(isr_pkg::MODE_DROP, 1'b0, 32'd0);
    put_request(isr_pkg::REQ_RECV, 32'd200, 16'h1234);
    put_request(isr_pkg::REQ_RECV, 32'd200, 16'h1235);
    put_request(isr_pkg::REQ_RECV, 32'd199, 16'h1236);
    put_request(isr_pkg::REQ_RECV, 32'hFFFF_FFFE, 16'h1237);
    put_request(isr_pkg::REQ_RECV, 32'd0, 16'h1238);

    // Hold mode again: the accepted number wraps and the drain crosses zero.
    configure(isr_pkg::MODE_HOLD, 1'b0, 32'd0);
    put_request(isr_pkg::REQ_RECV, 32'd0, 16'h0010);
    put_request(isr_pkg::REQ_RECV, 32'd1, 16'h0011);
    put_request(isr_pkg::REQ_RECV, 32'hFFFF_FFFF, 16'h5A5A);

    configure(isr_pkg::MODE_PASS, 1'b0, 32'd0);
    put_request(isr_pkg::REQ_RECV, 32'd7, 16'h5A5A);
    put_request(isr_pkg::REQ_SEND, 32'h5555_AAAA, 16'h00FF);

    configure(MODE_SPARE, 1'b0, 32'd0);
    put_request(isr_pkg::REQ_RECV, 32'd3, 16'hFF00);

    // Send counter loaded at both extremes; the first one wraps.
    configure(isr_pkg::MODE_HOLD, 1'b1, 32'hFFFF_FFFF);
    put_request(isr_pkg::REQ_SEND, 32'hAAAA_5555, 16'h0042);
    put_request(isr_pkg::REQ_SEND, 32'd0, 16'h0043);
    configure(isr_pkg::MODE_HOLD, 1'b1, 32'd0);
    put_request(isr_pkg::REQ_SEND, 32'd9, 16'h0044);
    directed_items = items_sent;

    // Random phases: each picks a setting, then runs a few traffic episodes.
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      mode_pick = (pick < 10) ? isr_pkg::MODE_HOLD : (pick < 14) ? isr_pkg::MODE_DROP :
                  (pick < 18) ? isr_pkg::MODE_PASS : MODE_SPARE;
      case ($urandom_range(0, 5))
        0:       configure(mode_pick, 1'b1, 32'd0);
        1:       configure(mode_pick, 1'b1, 32'hFFFF_FFFF);
        2:       configure(mode_pick, 1'b1, $urandom);
        default: configure(mode_pick, 1'b0, 32'd0);
      endcase
      repeat ($urandom_range(2, 6)) begin
        if (mode_pick == isr_pkg::MODE_HOLD) begin
          // A window just past the last accepted number, in some order, with some noise.
          wait_quiet();
          base  = rx_last;
          width = $urandom_range(1, SHELF_DEPTH - 1);
          shape = $urandom_range(ORDER_ASCENDING, ORDER_SHUFFLED);
          for (int j = 0; j < width; j++) begin
            order[j] = (shape == ORDER_DESCENDING) ? width - j : j + 1;
          end
          if (shape == ORDER_SHUFFLED) begin
            for (int j = width - 1; j > 0; j--) begin
              pos        = $urandom_range(0, j);
              tmp        = order[j];
              order[j]   = order[pos];
              order[pos] = tmp;
            end
          end
          for (int j = 0; j < width; j++) begin
            if ($urandom_range(0, 9) == 0) begin
              put_request(isr_pkg::REQ_SEND, $urandom, 16'($urandom_range(1, 16'hFFFF)));
            end
            if ($urandom_range(0, 99) < 12) begin
              put_request(isr_pkg::REQ_RECV, base - 32'd16 + $urandom_range(0, 56),
                          16'($urandom_range(1, 16'hFFFF)));
            end else begin
              put_request(isr_pkg::REQ_RECV, base + order[j],
                          16'($urandom_range(1, 16'hFFFF)));
            end
          end
        end else if (mode_pick == isr_pkg::MODE_DROP) begin
          // Numbers around the last delivered one, plus some anywhere in the range.
          wait_quiet();
          base = rx_last;
          repeat ($urandom_range(4, 12)) begin
            case ($urandom_range(0, 3))
              0:       put_request(isr_pkg::REQ_SEND, $urandom,
                                   16'($urandom_range(1, 16'hFFFF)));
              1:       put_request(isr_pkg::REQ_RECV, $urandom,
                                   16'($urandom_range(1, 16'hFFFF)));
              default: put_request(isr_pkg::REQ_RECV, base - 32'd4 + $urandom_range(0, 8),
                                   16'($urandom_range(1, 16'hFFFF)));
            endcase
          end
        end else begin
          repeat ($urandom_range(4, 12)) begin
            put_request(1'($urandom_range(0, 1)), $urandom,
                        16'($urandom_range(1, 16'hFFFF)));
          end
        end
      end
    end

    // Let every owed result arrive, then watch a little longer for strays.
    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d requests (%0d stamp requests) over %0d configuration phases.",
             items_sent, sends_sent, phases);
    $display("Checked %0d results; the longest run caused by one request was %0d.",
             results_checked, longest_run);
    if (mismatches == 0 && results_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
